// ===== hw/rtl/bgsd_pkg.sv =====
// ============================================================================
// bgsd_pkg: shared types and constants of the BMP gray stream decoder
// Holds the parser phases, result codes, result word layout and queue sizing.
// ============================================================================
package bgsd_pkg;

    // Largest accepted image width or height.
    localparam int MAX_DIM = 4096;

    // Header constants.
    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [31:0] DIB_MIN_SIZE  = 32'd40;
    localparam logic [15:0] BPP_RGB       = 16'd24;
    localparam logic [15:0] BPP_GRAY      = 16'd8;
    localparam logic [31:0] HEADER_BYTES  = 32'd54;

    // Header byte positions at which a field is complete.
    localparam logic [31:0] POS_SIGNATURE = 32'd1;
    localparam logic [31:0] POS_OFFSET    = 32'd13;
    localparam logic [31:0] POS_DIB_SIZE  = 32'd17;
    localparam logic [31:0] POS_WIDTH     = 32'd21;
    localparam logic [31:0] POS_HEIGHT    = 32'd25;
    localparam logic [31:0] POS_PLANES    = 32'd27;
    localparam logic [31:0] POS_BPP       = 32'd29;
    localparam logic [31:0] POS_COMPRESS  = 32'd33;
    localparam logic [31:0] POS_LAST_HDR  = 32'd53;

    // Result queue depth, in entries.
    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE,
        PH_FAULT
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_FINISH,
        KIND_ERROR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_SIGNATURE,
        ERR_DIB_SMALL,
        ERR_FORMAT,
        ERR_SIZE,
        ERR_OFFSET,
        ERR_TRUNCATED
    } err_t;

    // One result word.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  gray;
        logic [11:0] column;
        logic [11:0] row;
        logic [12:0] image_width;
        logic [12:0] image_height;
        err_t        error_code;
        logic        last;
    } result_t;

    // One queue entry: the results caused by one input word.
    typedef struct packed {
        result_t res0;
        result_t res1;
        logic    two;
    } entry_t;

endpackage

// ===== hw/rtl/bgsd_front.sv =====
// ============================================================================
// bgsd_front: header parser and pixel walker
// Consumes one file word per accepted cycle and forms the results it causes.
// ============================================================================
module bgsd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            end_of_file,
    output logic            push,
    output bgsd_pkg::entry_t push_entry
);
    import bgsd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] offset_reg, offset_next;
    logic [12:0] width_reg, width_next, width_upd;
    logic [12:0] height_reg, height_next, height_upd;
    logic        rgb_reg, rgb_next;
    logic [14:0] stride_reg, stride_next;
    logic [12:0] srow_reg, srow_next;
    logic [9:0]  sum_reg, sum_next;
    logic [1:0]  cidx_reg, cidx_next;
    logic [12:0] col_reg, col_next;
    logic        fmt_reg, fmt_next;
    logic        size_reg, size_next;

    logic        px_v, fin_v, hfail_v, trunc_v, do_pix;
    err_t        hfail_code;
    logic [7:0]  pix_gray;
    logic [11:0] pix_col;
    logic [14:0] used, stride_len, sp;
    logic [11:0] pix_row;
    logic [9:0]  csum;
    logic [12:0] srow_inc;

    // Divide a color sum (at most 765) by three with a reciprocal multiply.
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [20:0] prod;
        prod = {11'd0, s} * 21'd683;
        return prod[18:11];
    endfunction

    function automatic logic size_ok(input logic [31:0] v);
        return (v != 32'd0) && (v <= 32'(MAX_DIM));
    endfunction

    // Row geometry from the parsed header.
    always_comb begin
        used       = rgb_reg ? ({2'b00, width_reg} + {1'b0, width_reg, 1'b0})
                             : {2'b00, width_reg};
        stride_len = (used + 15'd3) & ~15'd3;
        pix_row    = 12'(height_reg - 13'd1 - srow_reg);
    end

    // Next state of the parser.
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        shift_next  = shift_reg;
        offset_next = offset_reg;
        width_upd   = width_reg;
        height_upd  = height_reg;
        rgb_next    = rgb_reg;
        stride_next = stride_reg;
        srow_next   = srow_reg;
        sum_next    = sum_reg;
        cidx_next   = cidx_reg;
        col_next    = col_reg;
        fmt_next    = fmt_reg;
        size_next   = size_reg;
        px_v        = 1'b0;
        fin_v       = 1'b0;
        hfail_v     = 1'b0;
        hfail_code  = ERR_NONE;
        trunc_v     = 1'b0;
        do_pix      = 1'b0;
        pix_gray    = data_byte;
        pix_col     = col_reg[11:0];
        csum        = sum_reg + {2'b00, data_byte};
        sp          = stride_reg + 15'd1;
        srow_inc    = srow_reg + 13'd1;

        if (accept) begin
            pos_next = pos_reg + 32'd1;
            unique case (phase_reg)
                PH_HEADER: begin
                    shift_next = {data_byte, shift_reg[31:8]};
                    case (pos_reg)
                        POS_SIGNATURE: begin
                            if (shift_next[31:16] != BMP_SIGNATURE) begin
                                hfail_v    = 1'b1;
                                hfail_code = ERR_SIGNATURE;
                            end
                        end
                        POS_OFFSET: offset_next = shift_next;
                        POS_DIB_SIZE: begin
                            if (shift_next < DIB_MIN_SIZE) begin
                                hfail_v    = 1'b1;
                                hfail_code = ERR_DIB_SMALL;
                            end
                        end
                        POS_WIDTH: begin
                            width_upd = shift_next[12:0];
                            if (!size_ok(shift_next)) size_next = 1'b1;
                        end
                        POS_HEIGHT: begin
                            height_upd = shift_next[12:0];
                            if (!size_ok(shift_next)) size_next = 1'b1;
                        end
                        POS_PLANES: begin
                            if (shift_next[31:16] != 16'd1) fmt_next = 1'b1;
                        end
                        POS_BPP: begin
                            if (shift_next[31:16] == BPP_RGB) rgb_next = 1'b1;
                            else if (shift_next[31:16] != BPP_GRAY) fmt_next = 1'b1;
                        end
                        POS_COMPRESS: begin
                            if (shift_next != 32'd0) fmt_next = 1'b1;
                        end
                        POS_LAST_HDR: begin
                            if (fmt_reg) begin
                                hfail_v    = 1'b1;
                                hfail_code = ERR_FORMAT;
                            end else if (size_reg) begin
                                hfail_v    = 1'b1;
                                hfail_code = ERR_SIZE;
                            end else if (offset_reg < HEADER_BYTES) begin
                                hfail_v    = 1'b1;
                                hfail_code = ERR_OFFSET;
                            end else begin
                                phase_next = (offset_reg == HEADER_BYTES) ? PH_PIXELS
                                                                          : PH_SKIP;
                            end
                        end
                        default: ;
                    endcase
                    if (hfail_v) phase_next = PH_FAULT;
                end
                PH_SKIP: begin
                    if (pos_reg >= offset_reg) begin
                        phase_next = PH_PIXELS;
                        do_pix     = 1'b1;
                    end
                end
                PH_PIXELS: do_pix = 1'b1;
                default: ;
            endcase

            // Walk one byte of a padded row.
            if (do_pix) begin
                if (stride_reg < used) begin
                    if (rgb_reg) begin
                        if (cidx_reg == 2'd2) begin
                            px_v      = 1'b1;
                            pix_gray  = div3(csum);
                            sum_next  = 10'd0;
                            cidx_next = 2'd0;
                            col_next  = col_reg + 13'd1;
                        end else begin
                            sum_next  = csum;
                            cidx_next = cidx_reg + 2'd1;
                        end
                    end else begin
                        px_v     = 1'b1;
                        col_next = col_reg + 13'd1;
                    end
                end
                stride_next = sp;
                if (sp >= stride_len) begin
                    stride_next = 15'd0;
                    sum_next    = 10'd0;
                    cidx_next   = 2'd0;
                    col_next    = 13'd0;
                    srow_next   = srow_inc;
                    if (srow_inc >= height_reg) begin
                        fin_v      = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
            end

            // End of file: report a truncated image if it is unfinished, then start over.
            if (end_of_file) begin
                trunc_v = (phase_next == PH_HEADER) || (phase_next == PH_SKIP) ||
                          (phase_next == PH_PIXELS);
                phase_next  = PH_HEADER;
                pos_next    = 32'd0;
                shift_next  = 32'd0;
                offset_next = 32'd0;
                rgb_next    = 1'b0;
                stride_next = 15'd0;
                srow_next   = 13'd0;
                sum_next    = 10'd0;
                cidx_next   = 2'd0;
                col_next    = 13'd0;
                fmt_next    = 1'b0;
                size_next   = 1'b0;
            end
        end

        width_next  = (accept && end_of_file) ? 13'd0 : width_upd;
        height_next = (accept && end_of_file) ? 13'd0 : height_upd;
    end

    // Result words for the current byte.
    always_comb begin
        result_t pix, mk;
        logic    mk_v;
        pix.kind         = KIND_PIXEL;
        pix.gray         = pix_gray;
        pix.column       = pix_col;
        pix.row          = pix_row;
        pix.image_width  = width_reg;
        pix.image_height = height_reg;
        pix.error_code   = ERR_NONE;
        pix.last         = 1'b0;

        mk_v             = fin_v || hfail_v || trunc_v;
        mk.kind          = fin_v ? KIND_FINISH : KIND_ERROR;
        mk.gray          = 8'd0;
        mk.column        = 12'd0;
        mk.row           = 12'd0;
        mk.image_width   = width_upd;
        mk.image_height  = height_upd;
        mk.error_code    = fin_v ? ERR_NONE : (hfail_v ? hfail_code : ERR_TRUNCATED);
        mk.last          = 1'b1;

        push            = accept && (px_v || mk_v);
        push_entry.res0 = px_v ? pix : mk;
        push_entry.res1 = mk;
        push_entry.two  = px_v && mk_v;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= 32'd0;
            shift_reg  <= 32'd0;
            offset_reg <= 32'd0;
            width_reg  <= 13'd0;
            height_reg <= 13'd0;
            rgb_reg    <= 1'b0;
            stride_reg <= 15'd0;
            srow_reg   <= 13'd0;
            sum_reg    <= 10'd0;
            cidx_reg   <= 2'd0;
            col_reg    <= 13'd0;
            fmt_reg    <= 1'b0;
            size_reg   <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            rgb_reg    <= rgb_next;
            stride_reg <= stride_next;
            srow_reg   <= srow_next;
            sum_reg    <= sum_next;
            cidx_reg   <= cidx_next;
            col_reg    <= col_next;
            fmt_reg    <= fmt_next;
            size_reg   <= size_next;
        end
    end

endmodule

// ===== hw/rtl/bgsd_queue.sv =====
// ============================================================================
// bgsd_queue: short result queue
// Decouples the parser from the output stage; one entry per input word that causes results.
// ============================================================================
module bgsd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  bgsd_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output bgsd_pkg::entry_t head_entry
);
    import bgsd_pkg::*;

    entry_t              q_reg [QDEPTH];
    logic [QIDX_W-1:0]   wptr_reg, wptr_next;
    logic [QIDX_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    // Status and head of the queue.
    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = q_reg[rptr_reg];

    // Pointer and count update.
    always_comb begin
        wptr_next = push ? wptr_reg + QIDX_W'(1) : wptr_reg;
        rptr_next = pop  ? rptr_reg + QIDX_W'(1) : rptr_reg;
        cnt_next  = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) q_reg[wptr_reg] <= push_entry;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> !full)
        else $error("Queue written while full.");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("Queue read while empty.");
`endif

endmodule

// ===== hw/rtl/bgsd_back.sv =====
// ============================================================================
// bgsd_back: result serializer and output register
// Sends the one or two results of each queue entry as separate words.
// ============================================================================
module bgsd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  bgsd_pkg::entry_t  head_entry,
    output logic              pop,
    input  logic              m_ready,
    output logic              m_valid,
    output bgsd_pkg::result_t m_result
);
    import bgsd_pkg::*;

    logic    valid_reg, valid_next;
    logic    sel_reg, sel_next;
    result_t out_reg, out_next;
    logic    load;

    // Load a new word whenever the output register is free or drained.
    always_comb begin
        load       = head_valid && (!valid_reg || m_ready);
        pop        = load && (sel_reg || !head_entry.two);
        sel_next   = sel_reg;
        out_next   = out_reg;
        valid_next = valid_reg && !m_ready;
        if (load) begin
            out_next   = sel_reg ? head_entry.res1 : head_entry.res0;
            sel_next   = !pop;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid  = valid_reg;
    assign m_result = out_reg;

`ifndef SYNTH
    a_second_only_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg |-> (head_valid && head_entry.two))
        else $error("Second result selected without a paired entry.");
    a_last_is_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && out_reg.last) |-> (out_reg.kind != KIND_PIXEL))
        else $error("Pixel word flagged as last.");
`endif

endmodule

// ===== hw/rtl/bmp_gray_stream_decoder_unit.sv =====
// ============================================================================
// bmp_gray_stream_decoder_unit: streaming BMP to gray pixel decoder
// Parses an 8 or 24 bit BMP byte stream and emits gray pixels and markers.
// ============================================================================
//  Channel | Direction | Word
//  s_      | in        | data_byte, end_of_file
//  m_      | out       | kind, gray, column, row, image_width, image_height,
//          |           | error_code, last
//
//  One byte is accepted per cycle while the queue has room; a byte causes
//  zero, one or two result words, and two results leave as separate words.
//  A result word reaches m_ through the queue and then the output register
//  after its byte is accepted.
//  The four-entry queue between parser and output stage absorbs output stalls;
//  s_ready drops only when it is full. Reset is synchronous and active low.
module bmp_gray_stream_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_gray,
    output logic [11:0] m_column,
    output logic [11:0] m_row,
    output logic [12:0] m_image_width,
    output logic [12:0] m_image_height,
    output logic [2:0]  m_error_code,
    output logic        m_last
);
    import bgsd_pkg::*;

    logic    q_full, head_valid, pop, push, accept;
    entry_t  push_entry, head_entry;
    result_t res;

    // A word is taken whenever the queue has room.
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    bgsd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .data_byte   (s_data_byte),
        .end_of_file (s_end_of_file),
        .push        (push),
        .push_entry  (push_entry)
    );

    bgsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    bgsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_result   (res)
    );

    // Result word fields to ports.
    assign m_kind         = res.kind;
    assign m_gray         = res.gray;
    assign m_column       = res.column;
    assign m_row          = res.row;
    assign m_image_width  = res.image_width;
    assign m_image_height = res.image_height;
    assign m_error_code   = res.error_code;
    assign m_last         = res.last;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench of the BMP gray stream decoder
// Builds BMP files byte by byte, predicts the gray pixels and end markers of
// each word sent, and checks every result word against that prediction while
// both sides idle and stall at random.
// ============================================================================
module tb_top;
    import bgsd_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_end_of_file;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [7:0]  m_gray;
    logic [11:0] m_column;
    logic [11:0] m_row;
    logic [12:0] m_image_width;
    logic [12:0] m_image_height;
    logic [2:0]  m_error_code;
    logic        m_last;

    bmp_gray_stream_decoder_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_end_of_file (s_end_of_file),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_gray        (m_gray),
        .m_column      (m_column),
        .m_row         (m_row),
        .m_image_width (m_image_width),
        .m_image_height(m_image_height),
        .m_error_code  (m_error_code),
        .m_last        (m_last)
    );

    // Expected pixels and markers, oldest first.
    result_t     pending_results[$];
    int          mismatches;
    int          bytes_sent;
    bit          steady;
    int          rx_hold_cycles;
    logic [7:0]  file_bytes[$];

    // Decoder state as the testbench sees it.
    phase_t      ph;
    logic [31:0] hdr_pos;
    logic [31:0] hdr_shift;
    logic [31:0] pix_offset;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [31:0] col_pos;
    logic [31:0] src_row;
    logic [31:0] rgb_sum;
    logic [31:0] rgb_cnt;
    bit          rgb;
    bit          bad_format;
    bit          bad_size;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void clear_decoder();
        ph          = PH_HEADER;
        hdr_pos     = '0;
        hdr_shift   = '0;
        pix_offset  = '0;
        img_w       = '0;
        img_h       = '0;
        col_pos     = '0;
        src_row     = '0;
        rgb_sum     = '0;
        rgb_cnt     = '0;
        rgb         = 1'b0;
        bad_format  = 1'b0;
        bad_size    = 1'b0;
    endfunction

    function automatic void push_result(kind_t k, logic [7:0] g, logic [31:0] c,
                                        logic [31:0] r, err_t e, logic l);
        result_t res;
        res.kind         = k;
        res.gray         = g;
        res.column       = c[11:0];
        res.row          = r[11:0];
        res.image_width  = img_w[12:0];
        res.image_height = img_h[12:0];
        res.error_code   = e;
        res.last         = l;
        pending_results.insert(pending_results.size(), res);
    endfunction

    function automatic void raise_error(err_t e);
        push_result(KIND_ERROR, 8'd0, 0, 0, e, 1'b1);
        ph = PH_FAULT;
    endfunction

    function automatic bit dim_ok(logic [31:0] v);
        return v != 0 && v <= MAX_DIM;
    endfunction

    // One header byte: shift it in and check the field it completes.
    function automatic void decode_header(logic [7:0] b);
        hdr_shift = {b, hdr_shift[31:8]};
        case (hdr_pos)
            POS_SIGNATURE: if (hdr_shift[31:16] != BMP_SIGNATURE) raise_error(ERR_SIGNATURE);
            POS_OFFSET:    pix_offset = hdr_shift;
            POS_DIB_SIZE:  if (hdr_shift < DIB_MIN_SIZE) raise_error(ERR_DIB_SMALL);
            POS_WIDTH: begin
                img_w = hdr_shift & 32'h3FFF;
                if (!dim_ok(hdr_shift)) bad_size = 1'b1;
            end
            POS_HEIGHT: begin
                img_h = hdr_shift & 32'h3FFF;
                if (!dim_ok(hdr_shift)) bad_size = 1'b1;
            end
            POS_PLANES:    if (hdr_shift[31:16] != 16'd1) bad_format = 1'b1;
            POS_BPP: begin
                if (hdr_shift[31:16] == BPP_RGB) rgb = 1'b1;
                else if (hdr_shift[31:16] != BPP_GRAY) bad_format = 1'b1;
            end
            POS_COMPRESS:  if (hdr_shift != 0) bad_format = 1'b1;
            POS_LAST_HDR: begin
                if (bad_format) raise_error(ERR_FORMAT);
                else if (bad_size) raise_error(ERR_SIZE);
                else if (pix_offset < HEADER_BYTES) raise_error(ERR_OFFSET);
                else ph = (pix_offset == HEADER_BYTES) ? PH_PIXELS : PH_SKIP;
            end
            default: ;
        endcase
    endfunction

    // One pixel data byte: rows are bottom-up and padded to four bytes.
    function automatic void decode_pixel(logic [7:0] b);
        logic [31:0] used;
        logic [31:0] stride;
        logic [31:0] out_row;
        used    = rgb ? img_w * 3 : img_w;
        stride  = (used + 3) & ~32'd3;
        out_row = img_h - 1 - src_row;
        if (col_pos < used) begin
            if (rgb) begin
                rgb_sum = rgb_sum + b;
                rgb_cnt = rgb_cnt + 1;
                if (rgb_cnt >= 3) begin
                    push_result(KIND_PIXEL, 8'(rgb_sum / 3), col_pos / 3, out_row,
                                ERR_NONE, 1'b0);
                    rgb_sum = 0;
                    rgb_cnt = 0;
                end
            end else begin
                push_result(KIND_PIXEL, b, col_pos, out_row, ERR_NONE, 1'b0);
            end
        end
        col_pos = col_pos + 1;
        if (col_pos >= stride) begin
            col_pos = 0;
            rgb_sum = 0;
            rgb_cnt = 0;
            src_row = src_row + 1;
            if (src_row >= img_h) begin
                push_result(KIND_FINISH, 8'd0, 0, 0, ERR_NONE, 1'b1);
                ph = PH_DONE;
            end
        end
    endfunction

    function automatic void predict_decode(logic [7:0] b, logic eof);
        case (ph)
            PH_HEADER: decode_header(b);
            PH_SKIP: begin
                if (hdr_pos >= pix_offset) begin
                    ph = PH_PIXELS;
                    decode_pixel(b);
                end
            end
            PH_PIXELS: decode_pixel(b);
            default: ;
        endcase
        hdr_pos = hdr_pos + 1;
        if (eof) begin
            if (ph == PH_HEADER || ph == PH_SKIP || ph == PH_PIXELS)
                raise_error(ERR_TRUNCATED);
            clear_decoder();
        end
    endfunction

    // Send one word, after a random idle gap unless steady, and predict its results once accepted.
    task automatic send_byte(logic [7:0] b, logic eof);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_end_of_file <= eof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_decode(b, eof);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic void add_byte(logic [7:0] v);
        file_bytes.insert(file_bytes.size(), v);
    endfunction

    function automatic void put16(int v);
        add_byte(v[7:0]);
        add_byte(v[15:8]);
    endfunction

    function automatic void put32(logic [31:0] v);
        put16(v[15:0]);
        put16(v[31:16]);
    endfunction

    // Build a whole file; fill below zero means random pixel bytes.
    function automatic void build_file(logic [31:0] w, logic [31:0] h, int bpp,
                                       logic [31:0] off, int fill,
                                       int planes = 1, logic [31:0] comp = 0,
                                       logic [31:0] dib = 40, int sig = 16'h4D42);
        int row_bytes;
        file_bytes.delete();
        put16(sig);
        put32($urandom);
        put32($urandom);
        put32(off);
        put32(dib);
        put32(w);
        put32(h);
        put16(planes);
        put16(bpp);
        put32(comp);
        repeat (20) add_byte(8'($urandom_range(0, 255)));
        for (int i = 54; i < int'(off); i++) add_byte(8'($urandom_range(0, 255)));
        row_bytes = ((bpp == 24 ? 3 : 1) * int'(w) + 3) & ~3;
        if (w <= MAX_DIM && h <= MAX_DIM && w * h <= 4096)
            for (int i = 0; i < row_bytes * int'(h); i++)
                add_byte(fill < 0 ? 8'($urandom_range(0, 255)) : fill[7:0]);
    endfunction

    // Send the file, then tail extra bytes; end of file goes on the last one.
    task automatic send_file(int tail = 0);
        int n;
        n = file_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(file_bytes[i], tail == 0 && i == n - 1);
        for (int i = 0; i < tail; i++)
            send_byte(8'($urandom_range(0, 255)), i == tail - 1);
    endtask

    // Receiver: stall at random, then take and check one result word.
    initial begin
        int stall;
        result_t want;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 7);
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (pending_results.size() == 0) begin
                $error("result word with none expected: kind %0d", m_kind);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_kind != want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_kind);
                    mismatches++;
                end
                if (m_gray != want.gray) begin
                    $error("gray: expected %0d, got %0d", want.gray, m_gray);
                    mismatches++;
                end
                if (m_column != want.column) begin
                    $error("column: expected %0d, got %0d", want.column, m_column);
                    mismatches++;
                end
                if (m_row != want.row) begin
                    $error("row: expected %0d, got %0d", want.row, m_row);
                    mismatches++;
                end
                if (m_image_width != want.image_width) begin
                    $error("image_width: expected %0d, got %0d", want.image_width,
                           m_image_width);
                    mismatches++;
                end
                if (m_image_height != want.image_height) begin
                    $error("image_height: expected %0d, got %0d", want.image_height,
                           m_image_height);
                    mismatches++;
                end
                if (m_error_code != want.error_code) begin
                    $error("error_code: expected %0d, got %0d", want.error_code,
                           m_error_code);
                    mismatches++;
                end
                if (m_last != want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    mismatches++;
                end
            end
        end
    end

    // Plain 8-bit and 24-bit images with padding, black and white pixels.
    task automatic test_valid_images();
        build_file(3, 2, 8, 54, -1);
        send_file();
        build_file(2, 2, 24, 54, 255);
        send_file();
        build_file(1, 1, 24, 54, 0);
        send_file();
        build_file(5, 3, 24, 54, -1);
        send_file();
        wait_drained();
    endtask

    // Every header fault, including offset below the header and negative height.
    task automatic test_header_faults();
        build_file(2, 2, 8, 54, -1, 1, 0, 40, 16'h4D43);
        send_file();
        build_file(2, 2, 8, 54, -1, 1, 0, 39);
        send_file();
        build_file(2, 2, 8, 54, -1, 2);
        send_file();
        build_file(2, 2, 16, 54, -1);
        send_file();
        build_file(2, 2, 8, 54, -1, 1, 1);
        send_file();
        build_file(0, 2, 8, 54, -1);
        send_file();
        build_file(2, 4097, 8, 54, -1);
        send_file();
        build_file(2, 32'hFFFF_FFFF, 8, 54, -1);
        send_file();
        build_file(2, 2, 8, 40, -1);
        send_file();
        build_file(2, 2, 8, 54, -1, 2, 1, 40);
        send_file();
        wait_drained();
    endtask

    // Gap bytes between header and pixel data.
    task automatic test_skip_offset();
        build_file(3, 2, 8, 55, -1);
        send_file();
        build_file(2, 2, 24, 61, -1);
        send_file();
        wait_drained();
    endtask

    // End of file in the header, in the gap, on a pixel and mid pixel.
    task automatic test_truncation();
        send_byte(8'h42, 1'b1);
        build_file(2, 2, 8, 54, -1);
        void'(file_bytes.pop_back());
        send_file();
        build_file(2, 2, 8, 60, -1);
        file_bytes = file_bytes[0:56];
        send_file();
        build_file(2, 2, 24, 54, -1);
        file_bytes = file_bytes[0:58];
        send_file();
        build_file(2, 2, 24, 54, -1);
        file_bytes = file_bytes[0:55];
        send_file();
        build_file(2, 2, 8, 54, -1);
        file_bytes = file_bytes[0:40];
        send_file();
        wait_drained();
    endtask

    // Bytes after the marker are ignored until end of file.
    task automatic test_trailing_bytes();
        build_file(2, 1, 8, 54, -1);
        send_file(5);
        build_file(2, 2, 8, 54, -1, 1, 0, 40, 16'h0000);
        send_file(3);
        wait_drained();
    endtask

    // Largest width and height, cut short after a few pixels: both sizes at
    // the limit and the top row index on the first source row.
    task automatic test_max_dims();
        build_file(MAX_DIM, 1, 8, 54, -1);
        file_bytes = file_bytes[0:63];
        steady = 1'b1;
        send_file();
        steady = 1'b0;
        build_file(1, MAX_DIM, 24, 54, -1);
        file_bytes = file_bytes[0:69];
        send_file();
        wait_drained();
    endtask

    // Receiver holds off for long while the sender keeps offering words.
    task automatic test_backpressure();
        rx_hold_cycles = 300;
        steady = 1'b1;
        build_file(8, 4, 8, 54, -1);
        send_file();
        build_file(4, 3, 24, 54, -1);
        send_file();
        steady = 1'b0;
        wait_drained();
    endtask

    // Random small images, mostly well formed, some damaged or cut short.
    task automatic test_random_files();
        int start;
        int idx;
        int cut;
        int sel;
        start = bytes_sent;
        while (bytes_sent - start < 200) begin
            steady = ($urandom_range(0, 4) == 0);
            build_file($urandom_range(1, 6), $urandom_range(1, 4),
                       $urandom_range(0, 1) ? 24 : 8,
                       $urandom_range(0, 2) == 0 ? 54 + $urandom_range(0, 6) : 54, -1);
            sel = $urandom_range(0, 19);
            if (sel < 3) begin
                idx = $urandom_range(0, 53);
                file_bytes[idx] = 8'($urandom_range(0, 255));
            end else if (sel < 6) begin
                cut = $urandom_range(0, file_bytes.size() - 2);
                file_bytes = file_bytes[0:cut];
            end
            send_file($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0);
        end
        steady = 1'b0;
        wait_drained();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data_byte    = '0;
        s_end_of_file  = 1'b0;
        mismatches     = 0;
        bytes_sent     = 0;
        steady         = 1'b0;
        rx_hold_cycles = 0;
        clear_decoder();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_valid_images();
        test_header_faults();
        test_skip_offset();
        test_truncation();
        test_trailing_bytes();
        test_max_dims();
        test_backpressure();
        test_random_files();

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== bmp_gray_stream_decoder_unit.f =====
hw/rtl/bgsd_pkg.sv
hw/rtl/bgsd_front.sv
hw/rtl/bgsd_queue.sv
hw/rtl/bgsd_back.sv
hw/rtl/bmp_gray_stream_decoder_unit.sv
test/tb_top.sv
